[hw/rtl/lcd_shadow_buffer_writer_unit_assert.svh]
// Assertion macros shared by the checker of the LCD shadow buffer writer.
`ifndef LCD_SHADOW_BUFFER_WRITER_UNIT_ASSERT_SVH
`define LCD_SHADOW_BUFFER_WRITER_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define LSBW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsbw: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define LSBW_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsbw: same-cycle check failed");

`endif

[hw/rtl/lsbw_pkg.sv]
// Package with constants, codes and types of the LCD shadow buffer writer.
`default_nettype none

package lsbw_pkg;

   // Geometry of the shadow copy of the screen.
   localparam int PAGES       = 8;
   localparam int COLUMNS     = 128;
   localparam int STORE_SIZE  = PAGES * COLUMNS;
   localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int ADDR_FULL_W = 13;

   // Field widths.
   localparam int PAGE_W    = 4;
   localparam int COL_W     = 8;
   localparam int BYTE_W    = 8;
   localparam int NIBBLE_W  = 4;
   localparam int BIT_CNT_W = 3;
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;

   // Reset values of the opcode registers.
   localparam logic [NIBBLE_W-1:0] RESET_PAGE_OP   = 4'd11;
   localparam logic [NIBBLE_W-1:0] RESET_COL_HI_OP = 4'd1;
   localparam logic [NIBBLE_W-1:0] RESET_COL_LO_OP = 4'd0;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_PAGE_OP   = 2'd0;
   localparam logic [1:0] REG_COL_HI_OP = 2'd1;
   localparam logic [1:0] REG_COL_LO_OP = 2'd2;

   // Request kinds.
   typedef enum logic [1:0] {
      CMD_COMMAND = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_OR      = 2'd2,
      CMD_AND     = 2'd3
   } cmd_code_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MERGE,
      ST_SHIFT
   } state_type;

   // Opcode nibbles from the register block.
   typedef struct packed {
      logic [NIBBLE_W-1:0] page_op;
      logic [NIBBLE_W-1:0] col_hi_op;
      logic [NIBBLE_W-1:0] col_lo_op;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;
      logic take_cmd;
      logic take_data;
      logic merge;
      logic shift;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic in_range;
      logic last_bit;
   } ctrl_status_type;

endpackage

`default_nettype wire

[hw/rtl/lsbw_if.sv]
// Request and response channel interfaces of the LCD shadow buffer writer.
`default_nettype none

interface lsbw_req_if;
   import lsbw_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        cmd;
   logic [BYTE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink (input valid, input cmd, input value, output ready);
endinterface

interface lsbw_rsp_if;
   logic valid;
   logic ready;
   logic serial_bit;
   logic a0_level;
   logic last_bit;

   modport source (output valid, output serial_bit, output a0_level, output last_bit,
                   input ready);
   modport sink (input valid, input serial_bit, input a0_level, input last_bit,
                 output ready);
endinterface

`default_nettype wire

[hw/rtl/lsbw_csr.sv]
// APB register block holding the three opcode nibbles.
`default_nettype none

module lsbw_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lsbw_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [lsbw_pkg::PDATA_W-1:0]  pwdata,
   output logic      [lsbw_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready,
   output lsbw_pkg::cfg_type                  cfg
);
   import lsbw_pkg::*;

   logic [NIBBLE_W-1:0] page_op_ff, page_op_in;
   logic [NIBBLE_W-1:0] col_hi_op_ff, col_hi_op_in;
   logic [NIBBLE_W-1:0] col_lo_op_ff, col_lo_op_in;
   logic                wr_en;
   logic [1:0]          reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // Write decode.
   always_comb begin
      page_op_in   = page_op_ff;
      col_hi_op_in = col_hi_op_ff;
      col_lo_op_in = col_lo_op_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PAGE_OP:   page_op_in   = pwdata[NIBBLE_W-1:0];
            REG_COL_HI_OP: col_hi_op_in = pwdata[NIBBLE_W-1:0];
            REG_COL_LO_OP: col_lo_op_in = pwdata[NIBBLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_op_ff   <= RESET_PAGE_OP;
         col_hi_op_ff <= RESET_COL_HI_OP;
         col_lo_op_ff <= RESET_COL_LO_OP;
      end else begin
         page_op_ff   <= page_op_in;
         col_hi_op_ff <= col_hi_op_in;
         col_lo_op_ff <= col_lo_op_in;
      end
   end

   // Read decode.
   always_comb begin
      unique case (reg_idx)
         REG_PAGE_OP:   prdata = PDATA_W'(page_op_ff);
         REG_COL_HI_OP: prdata = PDATA_W'(col_hi_op_ff);
         REG_COL_LO_OP: prdata = PDATA_W'(col_lo_op_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg.page_op   = page_op_ff;
   assign cfg.col_hi_op = col_hi_op_ff;
   assign cfg.col_lo_op = col_lo_op_ff;

endmodule

`default_nettype wire

[hw/rtl/lsbw_ctrl.sv]
// Controller state machine: clearing pass, request intake, merge and bit shifting.
`default_nettype none

module lsbw_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [1:0]              req_cmd,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  lsbw_pkg::ctrl_status_type    status,
   output lsbw_pkg::ctrl_cmd_type       ctrl_cmd
);
   import lsbw_pkg::*;

   state_type state_ff, state_in;
   logic      is_command;

   assign is_command = (req_cmd == CMD_COMMAND);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (is_command) state_in = ST_SHIFT;
               else if (status.in_range) state_in = ST_MERGE;
            end
         end
         ST_MERGE: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (rsp_ready && status.last_bit) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   // Outputs.
   always_comb begin
      ctrl_cmd  = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: ctrl_cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready          = 1'b1;
            ctrl_cmd.take_cmd  = req_valid & is_command;
            ctrl_cmd.take_data = req_valid & ~is_command & status.in_range;
         end
         ST_MERGE: ctrl_cmd.merge = 1'b1;
         ST_SHIFT: begin
            rsp_valid      = 1'b1;
            ctrl_cmd.shift = rsp_ready;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

[hw/rtl/lsbw_dp.sv]
// Datapath: pointers, shadow memory, merge logic and the output shifter.
`default_nettype none

module lsbw_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [1:0]                  req_cmd,
   input  wire logic [lsbw_pkg::BYTE_W-1:0] req_value,
   input  lsbw_pkg::cfg_type                cfg,
   input  lsbw_pkg::ctrl_cmd_type           ctrl_cmd,
   output lsbw_pkg::ctrl_status_type        status,
   output logic                             serial_bit,
   output logic                             a0_level,
   output logic                             last_bit
);
   import lsbw_pkg::*;

   logic [BYTE_W-1:0]      mem [STORE_SIZE];
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [PAGE_W-1:0]      page_ff, page_in;
   logic [COL_W-1:0]       col_ff, col_in;
   cmd_code_type           mode_ff;
   logic [BYTE_W-1:0]      byte_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [BYTE_W-1:0]      rd_ff;
   logic [BYTE_W-1:0]      shift_ff, shift_in;
   logic                   a0_ff, a0_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_FULL_W-1:0] addr_full;
   logic [ADDR_W-1:0]      addr_now;
   logic [BYTE_W-1:0]      merged;
   logic [NIBBLE_W-1:0]    hi_nib, lo_nib;

   assign hi_nib = req_value[BYTE_W-1:NIBBLE_W];
   assign lo_nib = req_value[NIBBLE_W-1:0];

   // Address of the entry under the pointers, and the bounds check.
   assign addr_full = ADDR_FULL_W'(page_ff) * ADDR_FULL_W'(COLUMNS) + ADDR_FULL_W'(col_ff);
   assign addr_now  = addr_full[ADDR_W-1:0];
   assign status.in_range = ({1'b0, page_ff} < (PAGE_W + 1)'(PAGES))
                         && ({1'b0, col_ff} < (COL_W + 1)'(COLUMNS));
   assign status.clear_done = (clr_addr_ff == ADDR_W'(STORE_SIZE - 1));
   assign status.last_bit   = (cnt_ff == {BIT_CNT_W{1'b1}});

   // Merge of the new byte with the stored byte.
   always_comb begin
      case (mode_ff)
         CMD_OR:  merged = byte_ff | rd_ff;
         CMD_AND: merged = byte_ff & rd_ff;
         default: merged = byte_ff;
      endcase
   end

   // Clearing pass counter.
   assign clr_addr_in = ctrl_cmd.clear_step ? clr_addr_ff + 1'b1 : clr_addr_ff;

   // Pointer updates: command decode in page, column-low, column-high order.
   always_comb begin
      page_in = page_ff;
      col_in  = col_ff;
      if (ctrl_cmd.take_cmd) begin
         if (hi_nib == cfg.page_op) page_in = PAGE_W'(lo_nib);
         if (hi_nib == cfg.col_lo_op) col_in[NIBBLE_W-1:0] = lo_nib;
         if (hi_nib == cfg.col_hi_op) col_in[COL_W-1:NIBBLE_W] = lo_nib;
      end else if (ctrl_cmd.merge) begin
         col_in = col_ff + 1'b1;
      end
   end

   // Output shifter and bit counter.
   always_comb begin
      shift_in = shift_ff;
      a0_in    = a0_ff;
      cnt_in   = cnt_ff;
      if (ctrl_cmd.take_cmd) begin
         shift_in = req_value;
         a0_in    = 1'b0;
         cnt_in   = '0;
      end else if (ctrl_cmd.merge) begin
         shift_in = merged;
         a0_in    = 1'b1;
         cnt_in   = '0;
      end else if (ctrl_cmd.shift) begin
         shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         page_ff     <= '0;
         col_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         page_ff     <= page_in;
         col_ff      <= col_in;
         cnt_ff      <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      a0_ff    <= a0_in;
      if (ctrl_cmd.take_data) begin
         mode_ff <= cmd_code_type'(req_cmd);
         byte_ff <= req_value;
         addr_ff <= addr_now;
      end
   end

   // Shadow memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.clear_step) mem[clr_addr_ff] <= '0;
      else if (ctrl_cmd.merge) mem[addr_ff] <= merged;
      if (ctrl_cmd.take_data) rd_ff <= mem[addr_now];
   end

   assign serial_bit = shift_ff[BYTE_W-1];
   assign a0_level   = a0_ff;
   assign last_bit   = status.last_bit;

endmodule

`default_nettype wire

[hw/rtl/lcd_shadow_buffer_writer_unit.sv]
// Top level of the LCD shadow buffer writer.
// A command request gives its first bit in the cycle after acceptance; a data request passes the merge state first.
// Each sent byte goes out of the shifter on the serial output, one bit per cycle while the response side is ready.
// One request is taken at a time: the next waits until the last bit of a byte is sent; a dropped one does not hold it.
// After reset a clearing pass zeroes all 1024 entries of the shadow memory; requests wait for it.
`default_nettype none

module lcd_shadow_buffer_writer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lsbw_req_if.sink                           req_ch,
   lsbw_rsp_if.source                         rsp_ch,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [lsbw_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [lsbw_pkg::PDATA_W-1:0]  pwdata,
   output logic      [lsbw_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready
);
   import lsbw_pkg::*;

   cfg_type         cfg;
   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type status;

   // Opcode registers.
   lsbw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencing of requests.
   lsbw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Shadow memory, pointers and shifter.
   lsbw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_ch.cmd),
      .req_value  (req_ch.value),
      .cfg        (cfg),
      .ctrl_cmd   (ctrl_cmd),
      .status     (status),
      .serial_bit (rsp_ch.serial_bit),
      .a0_level   (rsp_ch.a0_level),
      .last_bit   (rsp_ch.last_bit)
   );

endmodule

`default_nettype wire

[hw/rtl/lsbw_checker.sv]
// Port-level checker of the LCD shadow buffer writer, bound to the top level.
`default_nettype none
`include "lcd_shadow_buffer_writer_unit_assert.svh"

module lsbw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_cmd,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_serial_bit,
   input wire logic       rsp_a0_level,
   input wire logic       rsp_last_bit
);
   import lsbw_pkg::*;

   // A stalled response holds its payload.
   `LSBW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_serial_bit) && $stable(rsp_a0_level) && $stable(rsp_last_bit))

   // No new request is taken while a byte is being sent.
   `LSBW_ASSERT_SAME(a_one_at_a_time, rsp_valid, !req_ready)

   // A byte goes out without gaps until its last bit.
   `LSBW_ASSERT_NEXT(a_no_gap, rsp_valid && rsp_ready && !rsp_last_bit, rsp_valid && $stable(rsp_a0_level))

   // The last bit ends the burst.
   `LSBW_ASSERT_NEXT(a_burst_end, rsp_valid && rsp_ready && rsp_last_bit, !rsp_valid)

   // A command request starts a command byte at once.
   `LSBW_ASSERT_NEXT(a_cmd_start, req_valid && req_ready && req_cmd == CMD_COMMAND, rsp_valid && !rsp_a0_level && !rsp_last_bit)

endmodule

bind lcd_shadow_buffer_writer_unit lsbw_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_cmd        (req_ch.cmd),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_serial_bit (rsp_ch.serial_bit),
   .rsp_a0_level   (rsp_ch.a0_level),
   .rsp_last_bit   (rsp_ch.last_bit)
);

`default_nettype wire

[tb/sv/lcd_shadow_buffer_writer_unit_tb.sv]
// Self-checking testbench for the LCD shadow buffer writer: serial byte stream and shadow merges.
`timescale 1ns / 100ps

module lcd_shadow_buffer_writer_unit_tb;
   import lsbw_pkg::*;

   // Cycles to let pass after the last expected bit before touching the opcode registers.
   localparam int SETTLE_CYCLES = 12;

   // One expected bit on the serial response channel.
   typedef struct packed {
      logic serial_bit;
      logic a0_level;
      logic last_bit;
   } serial_expect_type;

   // Tracks the shadow copy and the pointers, and holds the bits the block still owes.
   class lcd_shadow_tracker;
      logic [BYTE_W-1:0] shadow [STORE_SIZE];
      logic [PAGE_W-1:0] page_ptr;
      logic [COL_W-1:0]  col_ptr;
      cfg_type           opcodes;
      serial_expect_type sent_bits [$];
      int                failures;

      function new();
         foreach (shadow[i]) shadow[i] = '0;
         page_ptr = '0;
         col_ptr = '0;
         opcodes.page_op = RESET_PAGE_OP;
         opcodes.col_hi_op = RESET_COL_HI_OP;
         opcodes.col_lo_op = RESET_COL_LO_OP;
         failures = 0;
      endfunction

      function void set_opcode(logic [1:0] idx, logic [NIBBLE_W-1:0] nib);
         case (idx)
            REG_PAGE_OP:   opcodes.page_op = nib;
            REG_COL_HI_OP: opcodes.col_hi_op = nib;
            REG_COL_LO_OP: opcodes.col_lo_op = nib;
            default: ;
         endcase
      endfunction

      // A sent byte leaves the block most significant bit first, the eighth bit flagged.
      function void push_byte(logic [BYTE_W-1:0] data_out, logic a0);
         for (int k = BYTE_W - 1; k >= 0; k--) begin
            sent_bits.push_back({data_out[k], a0, k == 0});
         end
      endfunction

      // Applies one accepted request and returns how many bits it will send.
      function int note_request(cmd_code_type kind, logic [BYTE_W-1:0] data_in);
         logic [NIBBLE_W-1:0] hi;
         logic [NIBBLE_W-1:0] lo;
         logic [ADDR_W-1:0]   entry_idx;
         logic [BYTE_W-1:0]   merged;
         hi = data_in[7:4];
         lo = data_in[3:0];
         if (kind == CMD_COMMAND) begin
            push_byte(data_in, 1'b0);
            if (hi == opcodes.page_op) page_ptr = lo;
            if (hi == opcodes.col_lo_op) col_ptr[3:0] = lo;
            if (hi == opcodes.col_hi_op) col_ptr[7:4] = lo;
            return BYTE_W;
         end
         // Data aimed outside the screen is dropped without a trace.
         if (page_ptr >= PAGES || col_ptr >= COLUMNS) return 0;
         entry_idx = ADDR_W'(int'(page_ptr) * COLUMNS + int'(col_ptr));
         case (kind)
            CMD_WRITE: merged = data_in;
            CMD_OR:    merged = data_in | shadow[entry_idx];
            default:   merged = data_in & shadow[entry_idx];
         endcase
         shadow[entry_idx] = merged;
         col_ptr = col_ptr + 1'b1;
         push_byte(merged, 1'b1);
         return BYTE_W;
      endfunction

      // Compares one accepted serial bit with the oldest expectation.
      function void check_bit(logic serial_bit, logic a0_level, logic last_bit);
         serial_expect_type want;
         if (sent_bits.size() == 0) begin
            $error("unexpected response: serial_bit %0b a0_level %0b last_bit %0b",
                   serial_bit, a0_level, last_bit);
            failures++;
            return;
         end
         want = sent_bits.pop_front();
         if (want.serial_bit !== serial_bit) begin
            $error("serial_bit mismatch: expected %0b, got %0b", want.serial_bit, serial_bit);
            failures++;
         end
         if (want.a0_level !== a0_level) begin
            $error("a0_level mismatch: expected %0b, got %0b", want.a0_level, a0_level);
            failures++;
         end
         if (want.last_bit !== last_bit) begin
            $error("last_bit mismatch: expected %0b, got %0b", want.last_bit, last_bit);
            failures++;
         end
      endfunction

      function int pending();
         return sent_bits.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [PDATA_W-1:0]  pwdata;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   lsbw_req_if req_ch ();
   lsbw_rsp_if rsp_ch ();

   lcd_shadow_buffer_writer_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   lcd_shadow_tracker   tracker;
   int                  gap_pct = 20;
   int                  stall_pct = 10;
   int                  bytes_sent = 0;
   logic [NIBBLE_W-1:0] op_pg;
   logic [NIBBLE_W-1:0] op_hi;
   logic [NIBBLE_W-1:0] op_lo;

   // 12 ns clock.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // The response side stalls in random bursts while stall_pct is nonzero.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Every accepted serial bit is checked at once.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         tracker.check_bit(rsp_ch.serial_bit, rsp_ch.a0_level, rsp_ch.last_bit);
      end
   end

   // Writes all three opcode registers through the APB port, junk in the unused bits.
   task automatic set_opcodes(logic [NIBBLE_W-1:0] pg, logic [NIBBLE_W-1:0] hi,
                              logic [NIBBLE_W-1:0] lo);
      logic [1:0]          regs [3];
      logic [NIBBLE_W-1:0] nibs [3];
      regs = '{REG_PAGE_OP, REG_COL_HI_OP, REG_COL_LO_OP};
      nibs = '{pg, hi, lo};
      for (int i = 0; i < 3; i++) begin
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= {regs[i], 2'b00};
         pwdata <= {28'($urandom_range(0, 32'h0FFF_FFFF)), nibs[i]};
         @(posedge clock);
         penable <= 1'b1;
         @(posedge clock);
         tracker.set_opcode(regs[i], nibs[i]);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      op_pg = pg;
      op_hi = hi;
      op_lo = lo;
   endtask

   // Offers one request, possibly after a random gap, and waits until it is taken.
   task automatic send_request(cmd_code_type kind, logic [BYTE_W-1:0] data_in);
      int unsigned gap;
      gap = 0;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 18);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= kind;
      req_ch.value <= data_in;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      if (tracker.note_request(kind, data_in) != 0) bytes_sent++;
   endtask

   // Holds the request side until every expected bit has come, then lets the block settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly pointer setup followed by runs of data, with some stray command bytes.
   task automatic run_random(int count);
      int                  start;
      int                  pick;
      logic [NIBBLE_W-1:0] lo;
      logic [BYTE_W-1:0]   data;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_request(CMD_COMMAND, 8'($urandom_range(0, 255)));
         end else if (pick < 27) begin
            // Pages are mostly kept low so that merges revisit written entries.
            if ($urandom_range(0, 9) == 0) lo = 4'($urandom_range(8, 15));
            else if ($urandom_range(0, 2) == 0) lo = 4'($urandom_range(0, 7));
            else lo = 4'($urandom_range(0, 1));
            send_request(CMD_COMMAND, {op_pg, lo});
         end else if (pick < 42) begin
            if ($urandom_range(0, 9) == 0) lo = 4'($urandom_range(8, 15));
            else if ($urandom_range(0, 2) == 0) lo = 4'($urandom_range(0, 7));
            else lo = 4'($urandom_range(0, 1));
            send_request(CMD_COMMAND, {op_hi, lo});
         end else if (pick < 55) begin
            send_request(CMD_COMMAND, {op_lo, 4'($urandom_range(0, 15))});
         end else begin
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 5))
                  0:       data = 8'h00;
                  1:       data = 8'hFF;
                  default: data = 8'($urandom_range(0, 255));
               endcase
               send_request(cmd_code_type'($urandom_range(1, 3)), data);
            end
         end
      end
   endtask

   // Run limit.
   initial begin
      #5000000;
      $display("lcd_shadow_buffer_writer_unit regression: fail");
      $finish;
   end

   // Main sequence.
   initial begin
      tracker = new();
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_COMMAND;
      req_ch.value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Default opcodes: merges, the right screen edge, pages off the screen, stray commands.
      set_opcodes(RESET_PAGE_OP, RESET_COL_HI_OP, RESET_COL_LO_OP);
      send_request(CMD_COMMAND, {op_lo, 4'h0});
      send_request(CMD_WRITE, 8'hFF);
      send_request(CMD_WRITE, 8'h00);
      send_request(CMD_COMMAND, {op_hi, 4'h0});
      send_request(CMD_COMMAND, {op_lo, 4'h0});
      send_request(CMD_OR, 8'h0F);
      send_request(CMD_AND, 8'hA5);
      send_request(CMD_AND, 8'h5A);
      send_request(CMD_COMMAND, {op_pg, 4'h7});
      send_request(CMD_COMMAND, {op_hi, 4'h7});
      send_request(CMD_COMMAND, {op_lo, 4'hF});
      send_request(CMD_WRITE, 8'h81);
      send_request(CMD_WRITE, 8'h55);
      send_request(CMD_OR, 8'hFF);
      send_request(CMD_AND, 8'hFF);
      send_request(CMD_COMMAND, {op_hi, 4'h0});
      send_request(CMD_COMMAND, {op_pg, 4'hF});
      send_request(CMD_WRITE, 8'h3C);
      send_request(CMD_COMMAND, {op_pg, 4'h8});
      send_request(CMD_OR, 8'h42);
      send_request(CMD_COMMAND, {op_pg, 4'h7});
      send_request(CMD_OR, 8'hF0);
      send_request(CMD_COMMAND, 8'hE3);
      send_request(CMD_COMMAND, 8'hFF);
      send_request(CMD_WRITE, 8'h7E);
      drain();

      // Page and column-low opcodes share a nibble, so one command moves both.
      set_opcodes(4'h0, 4'hF, 4'h0);
      send_request(CMD_COMMAND, 8'h03);
      send_request(CMD_COMMAND, 8'hF0);
      send_request(CMD_WRITE, 8'h3C);
      send_request(CMD_OR, 8'hC3);
      run_random(30);
      drain();

      // All opcodes at the top nibble.
      set_opcodes(4'hF, 4'hF, 4'hF);
      run_random(30);
      drain();

      // All opcodes at zero.
      set_opcodes(4'h0, 4'h0, 4'h0);
      run_random(30);
      drain();

      // Random opcodes, once with idling and once without.
      set_opcodes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)));
      run_random(30);
      drain();
      gap_pct = 0;
      stall_pct = 0;
      set_opcodes(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)));
      run_random(30);
      drain();

      // Back to the default opcodes, with gaps and stalls first and a quiet tail.
      gap_pct = 25;
      stall_pct = 15;
      set_opcodes(RESET_PAGE_OP, RESET_COL_HI_OP, RESET_COL_LO_OP);
      run_random(20);
      gap_pct = 0;
      stall_pct = 0;
      run_random(25);
      drain();

      if (tracker.failures == 0) begin
         $display("lcd_shadow_buffer_writer_unit regression: pass");
      end else begin
         $display("lcd_shadow_buffer_writer_unit regression: fail");
      end
      $finish;
   end

endmodule
